>>> src/smpf_pkg.sv
package smpf_pkg;

	// transform size limits
	localparam int unsigned MAX_FFT_LOG2 = 16;
	localparam int unsigned MIN_FFT_LOG2 = 4;

	// field widths
	localparam int unsigned PART_W     = 48;
	localparam int unsigned BIN_W      = 16;
	localparam int unsigned WIN_W      = 17;
	localparam int unsigned LOG2_W     = 5;
	localparam int unsigned SCALE_W    = 32;
	localparam int unsigned LEVEL_W    = 48;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;

	// datapath widths
	localparam int unsigned MAG_W  = PART_W + 1;        // floor sqrt of a 97 bit sum
	localparam int unsigned SUM_W  = 2 * PART_W + 2;    // padded to an even bit count
	localparam int unsigned REM_W  = MAG_W + 3;
	localparam int unsigned PROD_W = MAG_W + SCALE_W;

	// level is Q32.16 with scale in Q0.32, so the product drops 16 + log2 N bits
	localparam int unsigned LEVEL_FRAC_SHIFT = 16;

	// bit-serial step counts
	localparam int unsigned SQ_STEPS    = PART_W;
	localparam int unsigned ROOT_STEPS  = MAG_W;
	localparam int unsigned SCALE_STEPS = SCALE_W;
	localparam int unsigned STEP_CNT_W  = 6;

	// register reset values
	localparam logic [WIN_W-1:0]   START_BIN_RST = WIN_W'(1);
	localparam logic [WIN_W-1:0]   END_BIN_RST   = WIN_W'(32768);
	localparam logic [LOG2_W-1:0]  FFT_LOG2_RST  = LOG2_W'(16);
	localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(6842354);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BIN = 2'd0,
		CFG_END_BIN   = 2'd1,
		CFG_FFT_LOG2  = 2'd2,
		CFG_SCALE     = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_SCALE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic sq_step;
		logic rt_step;
	} mag_ctrl_t;

endpackage

>>> src/smpf_mag.sv
module smpf_mag (
	input  logic                                clk,
	input  smpf_pkg::mag_ctrl_t                 ctrl,
	input  logic signed [smpf_pkg::PART_W-1:0]  re_part,
	input  logic signed [smpf_pkg::PART_W-1:0]  im_part,
	output logic        [smpf_pkg::MAG_W-1:0]   mag
);

	localparam int unsigned PartW = smpf_pkg::PART_W;
	localparam int unsigned MagW  = smpf_pkg::MAG_W;
	localparam int unsigned SumW  = smpf_pkg::SUM_W;
	localparam int unsigned RemW  = smpf_pkg::REM_W;

	logic [PartW-1:0] abs_re;
	logic [PartW-1:0] abs_im;
	logic [PartW-1:0] are_q;
	logic [PartW-1:0] aim_q;
	logic [PartW-1:0] mre_q;
	logic [PartW-1:0] mim_q;
	logic [SumW-1:0]  acc_q;
	logic [SumW-1:0]  acc_next;
	logic [RemW-1:0]  rem_q;
	logic [RemW-1:0]  rem_shift;
	logic [RemW-1:0]  trial;
	logic [RemW-1:0]  rem_next;
	logic [MagW-1:0]  root_q;
	logic [MagW-1:0]  root_next;
	logic             fits;

	assign abs_re = re_part[PartW-1] ? (~re_part + 1'b1) : re_part;
	assign abs_im = im_part[PartW-1] ? (~im_part + 1'b1) : im_part;

	// msb-first shift-add, both squares summed in one accumulator
	always_comb begin
		acc_next = {acc_q[SumW-2:0], 1'b0}
			+ (mre_q[PartW-1] ? SumW'(are_q) : '0)
			+ (mim_q[PartW-1] ? SumW'(aim_q) : '0);
	end

	// restoring square root, one root bit per step
	always_comb begin
		rem_shift = {rem_q[RemW-3:0], acc_q[SumW-1 -: 2]};
		trial     = RemW'({root_q, 2'b01});
		fits      = (rem_shift >= trial);
		rem_next  = fits ? (rem_shift - trial) : rem_shift;
		root_next = {root_q[MagW-2:0], fits};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			are_q  <= abs_re;
			aim_q  <= abs_im;
			mre_q  <= abs_re;
			mim_q  <= abs_im;
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctrl.sq_step) begin
			acc_q <= acc_next;
			mre_q <= {mre_q[PartW-2:0], 1'b0};
			mim_q <= {mim_q[PartW-2:0], 1'b0};
		end else if (ctrl.rt_step) begin
			acc_q  <= {acc_q[SumW-3:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= root_next;
		end
	end

	assign mag = root_q;

endmodule

>>> src/spectrum_magnitude_peak_finder.sv
// an accepted word inside the search window runs through the squarer, square root and scaler
// phases to the result state; a word outside the window goes straight to the result state
// one word at a time: the input stays closed until the result is loaded, which waits on out_ready;
// the bit-serial squarer takes 48 steps, the square root 49 and the scaler 32
// reset: arst_n clears control, the peak and the output valid at once and loads
// the register defaults (start 1, end 32768, log2 size 16, scale 6842354)
module spectrum_magnitude_peak_finder #(
	parameter int unsigned MaxFftLog2 = smpf_pkg::MAX_FFT_LOG2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// register writes
	input  logic                                   cfg_we,
	input  logic        [smpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [smpf_pkg::CFG_DATA_W-1:0] cfg_data,
	// input word: one transform bin
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [smpf_pkg::PART_W-1:0]     re_part,
	input  logic signed [smpf_pkg::PART_W-1:0]     im_part,
	input  logic        [smpf_pkg::BIN_W-1:0]      bin_index,
	input  logic                                   last_bin,
	// output word: level of the bin and the running peak
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [smpf_pkg::LEVEL_W-1:0]    level,
	output logic                                   in_range,
	output logic        [smpf_pkg::LEVEL_W-1:0]    peak_level,
	output logic        [smpf_pkg::BIN_W-1:0]      peak_bin,
	output logic                                   frame_done
);

	localparam int unsigned WinW   = smpf_pkg::WIN_W;
	localparam int unsigned BinW   = smpf_pkg::BIN_W;
	localparam int unsigned Log2W  = smpf_pkg::LOG2_W;
	localparam int unsigned ScaleW = smpf_pkg::SCALE_W;
	localparam int unsigned LevelW = smpf_pkg::LEVEL_W;
	localparam int unsigned MagW   = smpf_pkg::MAG_W;
	localparam int unsigned ProdW  = smpf_pkg::PROD_W;
	localparam int unsigned CntW   = smpf_pkg::STEP_CNT_W;
	// window compare width: wide enough for the register and for N/2
	localparam int unsigned CmpW   = (MaxFftLog2 > WinW) ? MaxFftLog2 : WinW;
	localparam int unsigned ShW    = $clog2(smpf_pkg::LEVEL_FRAC_SHIFT + MaxFftLog2 + 1);

	// configuration registers
	logic [WinW-1:0]   start_bin_q;
	logic [WinW-1:0]   end_bin_q;
	logic [Log2W-1:0]  fft_log2_q;
	logic [ScaleW-1:0] scale_q;

	// control
	smpf_pkg::state_t    state_q;
	smpf_pkg::state_t    state_d;
	logic [CntW-1:0]     cnt_q;
	smpf_pkg::mag_ctrl_t mag_ctrl;
	logic                accept;
	logic                out_free;
	logic                sq_last;
	logic                root_last;
	logic                scale_last;
	logic                scale_load;
	logic                scale_step;
	logic                result_load;

	// word held while it is worked on
	logic [BinW-1:0] idx_q;
	logic            last_q;
	logic            inside_q;

	// window and scaling
	logic [Log2W-1:0]  k_eff;
	logic [CmpW-1:0]   half;
	logic [CmpW-1:0]   lo_b;
	logic [CmpW-1:0]   hi_b;
	logic [CmpW-1:0]   start_ext;
	logic [CmpW-1:0]   end_ext;
	logic [CmpW-1:0]   idx_ext;
	logic              inside_c;
	logic [ShW-1:0]    shift_amt;
	logic [ProdW-1:0]  prod_shifted;
	logic [LevelW-1:0] level_c;
	logic [MagW-1:0]   mag;
	logic [ScaleW-1:0] sc_q;
	logic [ProdW-1:0]  prod_q;

	// peak tracking
	logic [LevelW-1:0] best_level_q;
	logic [BinW-1:0]   best_bin_q;
	logic              take_peak;
	logic [LevelW-1:0] new_best_level;
	logic [BinW-1:0]   new_best_bin;

	// output register
	logic              out_valid_q;
	logic [LevelW-1:0] level_q;
	logic              in_range_q;
	logic [LevelW-1:0] peak_level_q;
	logic [BinW-1:0]   peak_bin_q;
	logic              frame_done_q;

	// ---------------------------------------------------------------------
	// register writes; indexes outside the list cannot be encoded
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bin_q <= smpf_pkg::START_BIN_RST;
			end_bin_q   <= smpf_pkg::END_BIN_RST;
			fft_log2_q  <= smpf_pkg::FFT_LOG2_RST;
			scale_q     <= smpf_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (smpf_pkg::cfg_reg_t'(cfg_index))
				smpf_pkg::CFG_START_BIN: start_bin_q <= cfg_data[WinW-1:0];
				smpf_pkg::CFG_END_BIN:   end_bin_q   <= cfg_data[WinW-1:0];
				smpf_pkg::CFG_FFT_LOG2:  fft_log2_q  <= cfg_data[Log2W-1:0];
				smpf_pkg::CFG_SCALE:     scale_q     <= cfg_data[ScaleW-1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// search window: log2 size clamped to its range, both edges to 1..N/2
	// ---------------------------------------------------------------------
	always_comb begin
		if (fft_log2_q < Log2W'(smpf_pkg::MIN_FFT_LOG2)) begin
			k_eff = Log2W'(smpf_pkg::MIN_FFT_LOG2);
		end else if (fft_log2_q > Log2W'(MaxFftLog2)) begin
			k_eff = Log2W'(MaxFftLog2);
		end else begin
			k_eff = fft_log2_q;
		end

		half      = CmpW'(1) << (k_eff - 1'b1);
		start_ext = CmpW'(start_bin_q);
		end_ext   = CmpW'(end_bin_q);
		idx_ext   = CmpW'(bin_index);

		if (start_ext == '0) begin
			lo_b = CmpW'(1);
		end else if (start_ext > half) begin
			lo_b = half;
		end else begin
			lo_b = start_ext;
		end

		if (end_ext == '0) begin
			hi_b = CmpW'(1);
		end else if (end_ext > half) begin
			hi_b = half;
		end else begin
			hi_b = end_ext;
		end

		// an empty window matches nothing
		inside_c = (idx_ext >= lo_b) && (idx_ext < hi_b);
	end

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign sq_last    = (cnt_q == CntW'(smpf_pkg::SQ_STEPS - 1));
	assign root_last  = (cnt_q == CntW'(smpf_pkg::ROOT_STEPS - 1));
	assign scale_last = (cnt_q == CntW'(smpf_pkg::SCALE_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smpf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = inside_c ? smpf_pkg::ST_SQUARE : smpf_pkg::ST_RESULT;
				end
			end
			smpf_pkg::ST_SQUARE: begin
				if (sq_last) begin
					state_d = smpf_pkg::ST_ROOT;
				end
			end
			smpf_pkg::ST_ROOT: begin
				if (root_last) begin
					state_d = smpf_pkg::ST_SCALE;
				end
			end
			smpf_pkg::ST_SCALE: begin
				if (scale_last) begin
					state_d = smpf_pkg::ST_RESULT;
				end
			end
			smpf_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = smpf_pkg::ST_IDLE;
				end
			end
			default: state_d = smpf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		mag_ctrl.load    = 1'b0;
		mag_ctrl.sq_step = 1'b0;
		mag_ctrl.rt_step = 1'b0;
		scale_load       = 1'b0;
		scale_step       = 1'b0;
		result_load      = 1'b0;
		unique case (state_q)
			smpf_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mag_ctrl.load = in_valid && inside_c;
			end
			smpf_pkg::ST_SQUARE: begin
				mag_ctrl.sq_step = 1'b1;
			end
			smpf_pkg::ST_ROOT: begin
				mag_ctrl.rt_step = 1'b1;
				scale_load       = root_last;
			end
			smpf_pkg::ST_SCALE: begin
				scale_step = 1'b1;
			end
			smpf_pkg::ST_RESULT: begin
				result_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smpf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			// step count restarts on every phase change
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// word fields kept for the result
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= bin_index;
			last_q   <= last_bin;
			inside_q <= inside_c;
		end
	end

	// ---------------------------------------------------------------------
	// magnitude: squares summed bit-serially, then square root
	// ---------------------------------------------------------------------
	smpf_mag u_mag (
		.clk     (clk),
		.ctrl    (mag_ctrl),
		.re_part (re_part),
		.im_part (im_part),
		.mag     (mag)
	);

	// ---------------------------------------------------------------------
	// scaling: magnitude times scale, one scale bit per cycle, msb first
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (scale_load) begin
			sc_q   <= scale_q;
			prod_q <= '0;
		end else if (scale_step) begin
			prod_q <= {prod_q[ProdW-2:0], 1'b0} + (sc_q[ScaleW-1] ? ProdW'(mag) : '0);
			sc_q   <= {sc_q[ScaleW-2:0], 1'b0};
		end
	end

	// drop 16 + log2 N fraction bits, saturate at full scale; words outside the window get level zero
	always_comb begin
		shift_amt    = ShW'(k_eff) + ShW'(smpf_pkg::LEVEL_FRAC_SHIFT);
		prod_shifted = prod_q >> shift_amt;
		if (!inside_q) begin
			level_c = '0;
		end else if (|prod_shifted[ProdW-1:LevelW]) begin
			level_c = '1;
		end else begin
			level_c = prod_shifted[LevelW-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// peak: strictly larger wins, so ties keep the earlier bin
	// ---------------------------------------------------------------------
	always_comb begin
		take_peak      = inside_q && (level_c > best_level_q);
		new_best_level = take_peak ? level_c : best_level_q;
		new_best_bin   = take_peak ? idx_q : best_bin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_level_q <= '0;
			best_bin_q   <= '0;
		end else if (result_load) begin
			// frame end reports the peak and starts the next frame clean
			best_level_q <= last_q ? '0 : new_best_level;
			best_bin_q   <= last_q ? '0 : new_best_bin;
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			level_q      <= level_c;
			in_range_q   <= inside_q;
			peak_level_q <= new_best_level;
			peak_bin_q   <= new_best_bin;
			frame_done_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign level      = level_q;
	assign in_range   = in_range_q;
	assign peak_level = peak_level_q;
	assign peak_bin   = peak_bin_q;
	assign frame_done = frame_done_q;

endmodule

>>> src/smpf_checker.sv
module smpf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [smpf_pkg::LEVEL_W-1:0]     level,
	input logic                             in_range,
	input logic [smpf_pkg::LEVEL_W-1:0]     peak_level,
	input logic [smpf_pkg::BIN_W-1:0]       peak_bin
);

	// a stalled result word is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// one word at a time: taking a word closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a word is in work");

	// bins outside the window carry no level
	a_out_of_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> level == '0)
		else $error("nonzero level outside the window");

	// the peak never falls below the level of the bin just reported
	a_peak_covers_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> peak_level >= level)
		else $error("peak below current level");

	// no peak bin without a peak above zero
	a_empty_peak_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && peak_level == '0 |-> peak_bin == '0)
		else $error("peak bin set with zero peak");

endmodule

bind spectrum_magnitude_peak_finder smpf_checker u_smpf_checker (.*);
